@@ design/olist_pkg.sv @@
// Shared request and status codes and the cell control bundle for the ordered list engine.
`default_nettype none

package olist_pkg;

    // Request kinds
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_INSERT     = 3'd4;
    localparam logic [2:0] REQ_SEARCH     = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Match bits examined per cycle while scanning for the first hit
    localparam int SCAN_LANES = 8;

    // Found index reported when nothing matches or for non-search requests
    localparam logic [4:0] FOUND_NONE = 5'b11111;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic insert;      // open a gap at the insert position and load the word
        logic shift_left;  // every cell takes its right neighbour (pop front)
        logic search;      // every cell compares its word with the key
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/olist_cell.sv @@
// One list cell: holds one word, shifts with its neighbours and compares against the key.
`default_nettype none

module olist_cell
    import olist_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  wire logic               clk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [CNT_W-1:0]   ins_pos,
    input  wire logic [31:0]        key,
    input  wire logic [31:0]        left_data,
    input  wire logic [31:0]        right_data,
    output logic [31:0]             data,
    output logic                    match
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [31:0] data_reg;
    logic        match_reg;

    // Load, shift right behind the insert point, or shift left on pop front
    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            if (IDX_C == ins_pos)
                data_reg <= key;
            else if (IDX_C > ins_pos)
                data_reg <= left_data;
        end
        else if (ctrl.shift_left)
        begin
            data_reg <= right_data;
        end
    end

    // Capture the compare result for the scan that follows
    always_ff @(posedge clk)
    begin
        if (ctrl.search)
            match_reg <= (data_reg == key);
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

@@ design/ordered_list_engine_unit.sv @@
// Top level of the ordered list engine: request decode, cell chain and first-match scan.
//
// Usage: a request (req_type, value, position) is taken at a rising edge where start
// is high and busy is low. Each request gives exactly one result (status, found_index,
// entry_count), shown for one cycle with done high; the receiver cannot stall it.
// Push, pop and insert requests act on all cells in parallel at the accepting edge:
// done follows one cycle later and busy stays low, so a new request may be taken in
// every cycle. A search registers one compare bit per cell at the accepting edge, then
// walks the match bits 8 per cycle, stopping at the first hit, with busy high while
// the match bits are walked; done is registered when the walk ends. How far the walk
// goes depends on where the first hit lies. Reset clears the entry count and the
// control state; the stored words are undefined until written and are never reported.
`default_nettype none

module ordered_list_engine_unit
    import olist_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         req_type,
    input  wire logic signed [31:0] value,
    input  wire logic [4:0]         position,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [4:0]       found_index,
    output logic [4:0]              entry_count
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PCMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int NCH    = (CAPACITY + SCAN_LANES - 1) / SCAN_LANES;
    localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int OFF_W  = $clog2(SCAN_LANES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CH_W-1:0]      chunk_reg, chunk_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [4:0]           found_reg, found_next;
    logic [4:0]           cnt_out_reg, cnt_out_next;

    cell_ctrl_t           ctrl;
    logic [CNT_W-1:0]     ins_pos;
    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [PCMP_W-1:0]    pos_ext;
    logic [PCMP_W-1:0]    cnt_ext;
    logic [31:0]          cnt_wide;

    logic [31:0]          cell_data [CAPACITY];
    logic [CAPACITY-1:0]  match_vec;
    logic [NCH*SCAN_LANES-1:0] hit_vec;
    logic [SCAN_LANES-1:0] lane_bits;
    logic                 lane_hit;
    logic [OFF_W-1:0]     lane_off;
    logic [31:0]          hit_wide;

    assign busy    = (state_reg == ST_SCAN);
    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = PCMP_W'(position);
    assign cnt_ext = PCMP_W'(count_reg);

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] left_d;
        logic [31:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        olist_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .ins_pos    (ins_pos),
            .key        (value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );

        // Only occupied cells take part in the scan
        assign hit_vec[i] = match_vec[i] && (CNT_W'(i) < count_reg);
    end

    for (genvar j = CAPACITY; j < NCH * SCAN_LANES; j++)
    begin : g_pad
        assign hit_vec[j] = 1'b0;
    end

    // Pick the lowest set bit of the current chunk
    assign lane_bits = hit_vec[chunk_reg * SCAN_LANES +: SCAN_LANES];

    always_comb
    begin
        lane_hit = 1'b0;
        lane_off = '0;
        for (int k = SCAN_LANES - 1; k >= 0; k--)
        begin
            if (lane_bits[k])
            begin
                lane_hit = 1'b1;
                lane_off = OFF_W'(k);
            end
        end
    end

    assign hit_wide = 32'(chunk_reg) * 32'(SCAN_LANES) + 32'(lane_off);
    assign cnt_wide = 32'(count_next);

    // Decode the transaction and sequence the scan
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        chunk_next   = chunk_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        cnt_out_next = cnt_out_reg;
        ctrl         = '0;
        ins_pos      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    found_next  = FOUND_NONE;
                    done_next   = 1'b1;
                    case (req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.insert = 1'b1;
                                ins_pos     = (req_type == REQ_PUSH_BACK) ? count_reg : '0;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.shift_left = 1'b1;
                                count_next      = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                                count_next = count_reg - CNT_W'(1);
                        end
                        REQ_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.insert = 1'b1;
                                ins_pos     = pos_ext[CNT_W-1:0];
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_SEARCH:
                        begin
                            ctrl.search = 1'b1;
                            done_next   = 1'b0;
                            chunk_next  = '0;
                            state_next  = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                    cnt_out_next = cnt_wide[4:0];
                end
            end
            ST_SCAN:
            begin
                if (lane_hit)
                begin
                    found_next = hit_wide[4:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (chunk_reg == CH_W'(NCH - 1))
                begin
                    found_next = FOUND_NONE;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    chunk_next = chunk_reg + CH_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            chunk_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            chunk_reg <= chunk_next;
            done_reg  <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        found_reg   <= found_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign entry_count = cnt_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("entry count moved during a search");

    a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (count_reg == $past(count_reg)))
        else $error("failed transaction changed the entry count");

    a_found_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg != FOUND_NONE) |-> (status_reg == ST_OK))
        else $error("match index reported with an error status");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (state_next == ST_IDLE)) |=> done_reg)
        else $error("search ended without a result");

endmodule

`default_nettype wire

@@ bench/tb_ordered_list_engine_unit.sv @@
// Self-checking testbench for the ordered list engine: directed edge cases, then random traffic.
`timescale 1ns / 100ps

module tb_ordered_list_engine_unit;
    import olist_pkg::*;

    localparam int LIST_DEPTH = 16;

    // Result of one transaction as the block reports it
    typedef struct {
        logic [1:0]        status;
        logic signed [4:0] found_index;
        logic [4:0]        entry_count;
    } list_result_t;

    // Traffic profiles for the random part
    typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIXED } traffic_mode_t;

    logic               clk = 1'b1;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         req_type = REQ_PUSH_FRONT;
    logic signed [31:0] value = '0;
    logic [4:0]         position = '0;
    wire logic          busy;
    wire logic          done;
    wire logic [1:0]    status;
    wire logic signed [4:0] found_index;
    wire logic [4:0]    entry_count;

    // Shadow copy of the list and the results still owed by the block
    logic signed [31:0] shadow_words [LIST_DEPTH];
    int                 shadow_len = 0;
    list_result_t       awaited_results [$];
    int                 mismatch_count = 0;
    int                 sender_idle_pct = 0;

    ordered_list_engine_unit #(.CAPACITY(LIST_DEPTH)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .entry_count (entry_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Apply one request to the shadow list and return what the block should report
    function automatic list_result_t apply_request(input logic [2:0] kind,
                                                   input logic signed [31:0] word,
                                                   input logic [4:0] pos);
        list_result_t res;
        int           i;
        int           slot;
        res.status      = ST_OK;
        res.found_index = FOUND_NONE;
        slot            = -1;
        case (kind)
            REQ_PUSH_FRONT:
                if (shadow_len >= LIST_DEPTH) res.status = ST_FULL;
                else slot = 0;
            REQ_PUSH_BACK:
                if (shadow_len >= LIST_DEPTH) res.status = ST_FULL;
                else slot = shadow_len;
            REQ_POP_FRONT:
                if (shadow_len == 0) res.status = ST_EMPTY;
                else
                begin
                    for (i = 0; i < shadow_len - 1; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_len--;
                end
            REQ_POP_BACK:
                if (shadow_len == 0) res.status = ST_EMPTY;
                else shadow_len--;
            REQ_INSERT:
                if (shadow_len >= LIST_DEPTH) res.status = ST_FULL;
                else if (int'(pos) > shadow_len) res.status = ST_BADPOS;
                else slot = int'(pos);
            REQ_SEARCH:
                for (i = shadow_len - 1; i >= 0; i--)
                    if (shadow_words[i] == word) res.found_index = i[4:0];
            default: ;
        endcase
        // Open a gap and load the word
        if (slot >= 0)
        begin
            for (i = shadow_len; i > slot; i--)
                shadow_words[i] = shadow_words[i - 1];
            shadow_words[slot] = word;
            shadow_len++;
        end
        res.entry_count = shadow_len[4:0];
        return res;
    endfunction

    // Check each result against the oldest expectation, then record newly accepted requests
    always @(posedge clk)
    begin
        list_result_t exp_res;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    mismatch_count++;
                end
                else
                begin
                    exp_res = awaited_results[0];
                    awaited_results.delete(0);
                    if (status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, status);
                        mismatch_count++;
                    end
                    if (found_index !== exp_res.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               exp_res.found_index, found_index);
                        mismatch_count++;
                    end
                    if (entry_count !== exp_res.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_res.entry_count, entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited_results.insert(awaited_results.size(),
                                       apply_request(req_type, value, position));
        end
    end

    // Offer one transaction, idling at random first, and wait until it is taken
    task automatic send_request(input logic [2:0] kind, input logic signed [31:0] word,
                                input logic [4:0] pos);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        value    <= word;
        position <= pos;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // Drop start and hold off until every outstanding result has arrived
    task automatic hold_until_drained();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            mismatch_count++;
        end
    endtask

    function automatic logic signed [31:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r < 5) return 32'($urandom_range(8)) - 32'sd4;
        if (r == 5)
        begin
            case ($urandom_range(3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Pops and searches on an empty list, unused kinds and inserts past the end
    task automatic test_empty_list();
        send_request(REQ_POP_FRONT, 32'sd0, 5'd0);
        send_request(REQ_POP_BACK, 32'sd0, 5'd0);
        send_request(REQ_SEARCH, 32'sd0, 5'd0);
        send_request(REQ_INSERT, 32'sd5, 5'd1);
        send_request(REQ_INSERT, 32'sd5, 5'd31);
        send_request(3'd6, $urandom, 5'd31);
        send_request(3'd7, $urandom, 5'd0);
    endtask

    // Insert at the front, append at the end, search hits and misses, pop the only entry
    task automatic test_insert_positions();
        send_request(REQ_INSERT, -32'sd1, 5'd0);
        send_request(REQ_PUSH_FRONT, 32'sh7fffffff, 5'd0);
        send_request(REQ_PUSH_BACK, 32'sh80000000, 5'd0);
        send_request(REQ_INSERT, 32'sd0, 5'd3);
        send_request(REQ_INSERT, 32'sd1, 5'd2);
        send_request(REQ_SEARCH, -32'sd1, 5'd0);
        send_request(REQ_SEARCH, 32'sh80000000, 5'd0);
        send_request(REQ_SEARCH, 32'sd12345, 5'd0);
        send_request(REQ_POP_FRONT, 32'sd0, 5'd0);
        repeat (3) send_request(REQ_POP_BACK, 32'sd0, 5'd0);
        send_request(REQ_POP_FRONT, 32'sd0, 5'd0);
        send_request(REQ_SEARCH, 32'sd0, 5'd0);
    endtask

    // Fill to capacity and try every way of overfilling
    task automatic test_full_list();
        int i;
        for (i = 0; i < LIST_DEPTH; i++)
            send_request(REQ_PUSH_BACK, i, 5'd0);
        send_request(REQ_PUSH_FRONT, 32'sd99, 5'd0);
        send_request(REQ_PUSH_BACK, 32'sd99, 5'd0);
        send_request(REQ_INSERT, 32'sd99, 5'd31);
        send_request(REQ_SEARCH, 32'sd15, 5'd0);
        send_request(REQ_POP_FRONT, 32'sd0, 5'd0);
    endtask

    // Bursts of growing, shrinking and mixed traffic with random content
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        traffic_mode_t mode;
        int            n;
        int            roll;
        int            len;
        int            p_push;
        int            p_insert;
        int            p_pop;
        logic [2:0]    kind;
        logic signed [31:0] word;
        logic [4:0]    pos;
        sender_idle_pct = idle_pct;
        mode = MODE_MIXED;
        for (n = 0; n < n_items; n++)
        begin
            if (n % 24 == 0)
                mode = traffic_mode_t'($urandom_range(2));
            case (mode)
                MODE_GROW:   begin p_push = 45; p_insert = 25; p_pop = 12; end
                MODE_SHRINK: begin p_push = 15; p_insert = 10; p_pop = 55; end
                default:     begin p_push = 25; p_insert = 20; p_pop = 30; end
            endcase
            len  = shadow_len;
            roll = $urandom_range(99);
            word = pick_word();
            pos  = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(len));
            if (roll < 2)
                kind = 3'($urandom_range(7, 6));
            else if (roll < p_push)
                kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else if (roll < p_push + p_insert)
                kind = REQ_INSERT;
            else if (roll < p_push + p_insert + p_pop)
                kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
            else
            begin
                kind = REQ_SEARCH;
                // Mostly look for a word that is in the list
                if (len > 0 && $urandom_range(9) < 7)
                    word = shadow_words[$urandom_range(len - 1)];
            end
            send_request(kind, word, pos);
        end
    endtask

    initial
    begin
        int waited;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_insert_positions();
        test_full_list();
        hold_until_drained();

        test_random_traffic(170, 15);
        hold_until_drained();
        test_random_traffic(170, 59);
        hold_until_drained();
        test_random_traffic(170, 0);
        hold_until_drained();

        // Allow a spurious late strobe to show up
        waited = 0;
        while (waited < 10)
        begin
            @(posedge clk);
            waited++;
        end
        if (mismatch_count == 0)
            $display("tb_ordered_list_engine_unit: done, clean");
        else
            $display("tb_ordered_list_engine_unit: done, errors");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("tb_ordered_list_engine_unit: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
design/olist_pkg.sv
design/olist_cell.sv
design/ordered_list_engine_unit.sv
bench/tb_ordered_list_engine_unit.sv
